// ----- rtl/vfr_pkg.sv -----
package vfr_pkg;

  // frame store geometry
  localparam int FRAME_BYTES   = 65536;
  localparam int ADDR_W        = $clog2(FRAME_BYTES);
  localparam int LEN_W         = ADDR_W + 1;

  // fragment bookkeeping
  localparam int MAX_FRAGMENTS = 1024;
  localparam int IDX_W         = $clog2(MAX_FRAGMENTS);

  // epoch tags stand in for the per-entry written and seen marks
  localparam int EPOCH_W = 16;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;

  // stream and configuration widths
  localparam int IN_DATA_W  = 264;
  localparam int OUT_DATA_W = 176;
  localparam int STATUS_W   = 3;
  localparam int CFG_W      = 17;

  // one frame store entry: epoch tag and byte
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [7:0]         data;
  } store_ent_t;

  // frame store write request
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [EPOCH_W-1:0] tag;
    logic [7:0]         data;
  } store_wr_t;

  // fragment seen write request
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   idx;
    logic [EPOCH_W-1:0] tag;
  } seen_wr_t;

endpackage

// ----- rtl/video_fragment_reassembler.sv -----
// Video fragment reassembler. Takes one stream transaction per cycle while in_tready is
// high: a payload byte of a fragment (in_tuser 0, with the full header repeated, in_tlast
// on the fragment's final byte) or a read of one assembled byte (in_tuser 1). The header
// is checked on the first byte of each fragment; accepted bytes go into a 64 KiB frame
// store whose entries carry an epoch tag, so that starting a new frame clears the written
// and seen marks at once. Results (one per read and per fragment end) leave through the
// stage one and output registers; the input keeps taking transactions while a result
// waits, until stage one holds another. Throughput is set by the single write and single
// read port of the frame store and the seen-mark memory. After reset the block runs a
// clearing pass before in_tready rises; the same pass runs once every 65535 frames when
// the epoch tag wraps, and at its last value a new transaction waits for stage one to empty.
module video_fragment_reassembler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [vfr_pkg::CFG_W-1:0]        cfg_wr_data,   // max_total_length
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // frame_sequence, frame_timestamp, fragment_index, fragment_count, frame_flags,
  // fragment_offset, total_length, fragment_length, data_byte, read_address
  input  logic [vfr_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tuser,      // mode
  input  logic                             in_tlast,      // last_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // done_sequence, done_timestamp, done_flags, done_length, bytes_gathered, read_data
  output logic [vfr_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [vfr_pkg::STATUS_W-1:0]     out_tuser      // status
);
  import vfr_pkg::*;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ      = 3'd4;

  localparam logic [1:0] VD_NONE   = 2'd0;
  localparam logic [1:0] VD_ACCEPT = 2'd1;
  localparam logic [1:0] VD_DUP    = 2'd2;
  localparam logic [1:0] VD_BAD    = 2'd3;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(FRAME_BYTES);

  // input transaction fields
  logic [31:0] in_seq;
  logic [63:0] in_ts;
  logic [15:0] in_idx;
  logic [15:0] in_cnt;
  logic [15:0] in_flags;
  logic [31:0] in_off;
  logic [31:0] in_tot;
  logic [31:0] in_len;
  logic [7:0]  in_data;
  logic [15:0] in_raddr;
  logic [31:0] lim;
  logic [31:0] room;
  logic        in_bad;
  logic        in_accept;

  logic [CFG_W-1:0] max_total_r;

  // stage one item
  logic              s1_valid_r;
  logic              s1_mode_r;
  logic              s1_last_r;
  logic              s1_bad_r;
  logic [31:0]       s1_seq_r;
  logic [63:0]       s1_ts_r;
  logic [15:0]       s1_cnt_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [15:0]       s1_flags_r;
  logic [LEN_W-1:0]  s1_off_r;
  logic [LEN_W-1:0]  s1_tot_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic [7:0]        s1_data_r;
  logic [ADDR_W-1:0] s1_raddr_r;

  // frame state
  logic               frame_active_r, frame_active_nxt;
  logic [31:0]        held_seq_r, held_seq_nxt;
  logic [63:0]        held_ts_r, held_ts_nxt;
  logic [15:0]        held_flags_r, held_flags_nxt;
  logic [15:0]        held_cnt_r, held_cnt_nxt;
  logic [LEN_W-1:0]   held_len_r, held_len_nxt;
  logic [31:0]        gathered_r, gathered_nxt;
  logic [LEN_W-1:0]   byte_pos_r, byte_pos_nxt;
  logic [1:0]         verdict_r, verdict_nxt;
  logic [LEN_W-1:0]   lat_off_r, lat_off_nxt;
  logic [LEN_W-1:0]   lat_len_r, lat_len_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;

  // same-edge write forwarding
  logic              fwd_st_v_r;
  logic [ADDR_W-1:0] fwd_st_addr_r;
  logic [7:0]        fwd_st_data_r;
  logic              fwd_sn_v_r;
  logic [IDX_W-1:0]  fwd_sn_idx_r;

  // output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [31:0]         out_seq_r;
  logic [63:0]         out_ts_r;
  logic [15:0]         out_flags_r;
  logic [LEN_W-1:0]    out_len_r;
  logic [31:0]         out_gath_r;
  logic [7:0]          out_rdata_r;

  // memory interface
  store_ent_t         st_rd;
  logic [EPOCH_W-1:0] sn_rtag;
  store_wr_t          st_wr;
  seen_wr_t           sn_wr;
  logic               wrap;
  logic               mem_busy;

  // stage one decisions
  logic                out_free;
  logic                s1_has_res;
  logic                s1_advance;
  logic                first;
  logic                newf;
  logic                seen_hit;
  logic [1:0]          verdict_eff;
  logic [31:0]         gath_base;
  logic [32:0]         gath_sum;
  logic [LEN_W:0]      wr_addr;
  logic [STATUS_W-1:0] status;
  logic [7:0]          rdata;
  logic                rd_hit;

  // unpack the input transaction
  assign in_seq    = in_tdata[31:0];
  assign in_ts     = in_tdata[95:32];
  assign in_idx    = in_tdata[111:96];
  assign in_cnt    = in_tdata[127:112];
  assign in_flags  = in_tdata[143:128];
  assign in_off    = in_tdata[175:144];
  assign in_tot    = in_tdata[207:176];
  assign in_len    = in_tdata[239:208];
  assign in_data   = in_tdata[247:240];
  assign in_raddr  = in_tdata[263:248];
  assign in_accept = in_tvalid && in_tready;

  // header checks that depend only on the transaction and the limit register
  assign lim    = ({15'b0, max_total_r} > 32'(FRAME_BYTES)) ? 32'(FRAME_BYTES)
                                                            : {15'b0, max_total_r};
  assign room   = in_tot - in_off;
  assign in_bad = (in_cnt == 16'd0) || (in_idx >= in_cnt) ||
                  ({1'b0, in_cnt} > 17'(MAX_FRAGMENTS)) || (in_tot > lim) ||
                  (in_off > in_tot) || (in_len > room);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_total_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      max_total_r <= cfg_wr_data;
    end
  end

  // flow control
  assign out_free   = !out_valid_r || out_tready;
  assign s1_has_res = s1_mode_r || s1_last_r;
  assign s1_advance = s1_valid_r && !mem_busy && (!s1_has_res || out_free);
  assign in_tready  = !mem_busy && (!s1_valid_r || (s1_advance && epoch_r != EPOCH_MAX));

  // stage one register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode_r  <= in_tuser;
      s1_last_r  <= in_tlast;
      s1_bad_r   <= in_bad;
      s1_seq_r   <= in_seq;
      s1_ts_r    <= in_ts;
      s1_cnt_r   <= in_cnt;
      s1_idx_r   <= in_idx[IDX_W-1:0];
      s1_flags_r <= in_flags;
      s1_off_r   <= in_off[LEN_W-1:0];
      s1_tot_r   <= in_tot[LEN_W-1:0];
      s1_len_r   <= in_len[LEN_W-1:0];
      s1_data_r  <= in_data;
      s1_raddr_r <= in_raddr[ADDR_W-1:0];
    end
  end

  // frame logic for the item in stage one
  always_comb begin
    frame_active_nxt = frame_active_r;
    held_seq_nxt     = held_seq_r;
    held_ts_nxt      = held_ts_r;
    held_flags_nxt   = held_flags_r;
    held_cnt_nxt     = held_cnt_r;
    held_len_nxt     = held_len_r;
    gathered_nxt     = gathered_r;
    byte_pos_nxt     = byte_pos_r;
    verdict_nxt      = verdict_r;
    lat_off_nxt      = lat_off_r;
    lat_len_nxt      = lat_len_r;
    epoch_nxt        = epoch_r;
    verdict_eff      = verdict_r;
    gath_base        = gathered_r;
    gath_sum         = {1'b0, gathered_r};
    wrap             = 1'b0;
    status           = ST_ACCEPTED;
    st_wr            = '0;
    sn_wr            = '0;
    wr_addr          = '0;

    first    = (byte_pos_r == '0);
    newf     = !frame_active_r || (s1_seq_r != held_seq_r) || (s1_ts_r != held_ts_r) ||
               (s1_cnt_r != held_cnt_r) || (s1_tot_r != held_len_r);
    seen_hit = (sn_rtag == epoch_r) || (fwd_sn_v_r && fwd_sn_idx_r == s1_idx_r);

    // read item: written bytes within the held length
    rd_hit = (fwd_st_v_r && fwd_st_addr_r == s1_raddr_r) || (st_rd.tag == epoch_r);
    rdata  = 8'd0;
    if (rd_hit && (LEN_W'(s1_raddr_r) < held_len_r)) begin
      rdata = (fwd_st_v_r && fwd_st_addr_r == s1_raddr_r) ? fwd_st_data_r : st_rd.data;
    end

    if (s1_valid_r && !s1_mode_r) begin
      // header decision on a fragment's first byte
      if (first) begin
        if (s1_bad_r) begin
          frame_active_nxt = 1'b0;
          verdict_eff      = VD_BAD;
        end else begin
          if (newf) begin
            frame_active_nxt = 1'b1;
            held_seq_nxt     = s1_seq_r;
            held_ts_nxt      = s1_ts_r;
            held_flags_nxt   = s1_flags_r;
            held_cnt_nxt     = s1_cnt_r;
            held_len_nxt     = s1_tot_r;
            gath_base        = 32'd0;
            wrap             = (epoch_r == EPOCH_MAX) && s1_advance;
            epoch_nxt        = (epoch_r == EPOCH_MAX) ? EPOCH_FIRST : epoch_r + EPOCH_W'(1);
          end
          if (!newf && seen_hit) begin
            verdict_eff = VD_DUP;
          end else begin
            verdict_eff  = VD_ACCEPT;
            gath_sum     = {1'b0, gath_base} + {{(33 - LEN_W){1'b0}}, s1_len_r};
            gathered_nxt = gath_sum[32] ? 32'hFFFF_FFFF : gath_sum[31:0];
            lat_off_nxt  = s1_off_r;
            lat_len_nxt  = s1_len_r;
            sn_wr.we     = s1_advance;
            sn_wr.idx    = s1_idx_r;
            sn_wr.tag    = epoch_nxt;
          end
        end
      end

      // payload byte write
      wr_addr = {1'b0, lat_off_nxt} + {1'b0, byte_pos_r};
      if (verdict_eff == VD_ACCEPT && byte_pos_r < lat_len_nxt &&
          wr_addr < (LEN_W + 1)'(FRAME_BYTES)) begin
        st_wr.we = s1_advance;
      end
      st_wr.addr = wr_addr[ADDR_W-1:0];
      st_wr.tag  = epoch_nxt;
      st_wr.data = s1_data_r;

      if (byte_pos_r < LEN_W'(FRAME_BYTES)) begin
        byte_pos_nxt = byte_pos_r + LEN_W'(1);
      end
      verdict_nxt = verdict_eff;

      // fragment end: status and completion
      if (s1_last_r) begin
        byte_pos_nxt = '0;
        verdict_nxt  = VD_NONE;
        if (verdict_eff == VD_BAD) begin
          status = ST_INVALID;
        end else begin
          status = (verdict_eff == VD_DUP) ? ST_DUPLICATE : ST_ACCEPTED;
          if (frame_active_nxt && gathered_nxt >= {{(32 - LEN_W){1'b0}}, held_len_nxt}) begin
            status           = ST_COMPLETE;
            frame_active_nxt = 1'b0;
          end
        end
      end
    end else begin
      status = ST_READ;
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r <= 1'b0;
      held_seq_r     <= '0;
      held_ts_r      <= '0;
      held_flags_r   <= '0;
      held_cnt_r     <= '0;
      held_len_r     <= '0;
      gathered_r     <= '0;
      byte_pos_r     <= '0;
      verdict_r      <= VD_NONE;
      lat_off_r      <= '0;
      lat_len_r      <= '0;
      epoch_r        <= EPOCH_FIRST;
    end else if (s1_advance) begin
      frame_active_r <= frame_active_nxt;
      held_seq_r     <= held_seq_nxt;
      held_ts_r      <= held_ts_nxt;
      held_flags_r   <= held_flags_nxt;
      held_cnt_r     <= held_cnt_nxt;
      held_len_r     <= held_len_nxt;
      gathered_r     <= gathered_nxt;
      byte_pos_r     <= byte_pos_nxt;
      verdict_r      <= verdict_nxt;
      lat_off_r      <= lat_off_nxt;
      lat_len_r      <= lat_len_nxt;
      epoch_r        <= epoch_nxt;
    end
  end

  // capture the writes that land on the same edge as a new read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_st_v_r <= 1'b0;
      fwd_sn_v_r <= 1'b0;
    end else if (in_accept) begin
      fwd_st_v_r <= st_wr.we;
      fwd_sn_v_r <= sn_wr.we;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_st_addr_r <= st_wr.addr;
      fwd_st_data_r <= st_wr.data;
      fwd_sn_idx_r  <= sn_wr.idx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && s1_has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_has_res) begin
      out_status_r <= status;
      out_seq_r    <= held_seq_nxt;
      out_ts_r     <= held_ts_nxt;
      out_flags_r  <= held_flags_nxt;
      out_len_r    <= held_len_nxt;
      out_gath_r   <= gathered_nxt;
      out_rdata_r  <= s1_mode_r ? rdata : 8'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'b0, out_rdata_r, out_gath_r, out_len_r, out_flags_r, out_ts_r,
                       out_seq_r};

  // frame store and seen marks
  vfr_mem u_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (in_accept),
    .store_raddr (in_raddr[ADDR_W-1:0]),
    .seen_raddr  (in_idx[IDX_W-1:0]),
    .store_rdata (st_rd),
    .seen_rtag   (sn_rtag),
    .store_wr    (st_wr),
    .seen_wr     (sn_wr),
    .wrap        (wrap),
    .busy        (mem_busy)
  );

  // no frame traffic reaches the memories during a clearing pass
  a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> !(st_wr.we || sn_wr.we || wrap))
    else $error("memory write during clearing pass");

  // tag zero marks cleared entries and is never the live epoch
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != EPOCH_NONE)
    else $error("live epoch is zero");

  // a result leaving stage one always lands in the output register
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance && s1_has_res |=> out_valid_r)
    else $error("result lost");

  // an accepted fragment never reaches past the held frame length
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    verdict_r == VD_ACCEPT |-> ({1'b0, lat_off_r} + {1'b0, lat_len_r}) <= {1'b0, held_len_r})
    else $error("accepted fragment overruns frame");

  // byte position saturates at the frame size
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= LEN_W'(FRAME_BYTES))
    else $error("byte position out of range");

endmodule

// ----- rtl/vfr_mem.sv -----
module vfr_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [vfr_pkg::ADDR_W-1:0]    store_raddr,
  input  logic [vfr_pkg::IDX_W-1:0]     seen_raddr,
  output vfr_pkg::store_ent_t           store_rdata,
  output logic [vfr_pkg::EPOCH_W-1:0]   seen_rtag,
  input  vfr_pkg::store_wr_t            store_wr,
  input  vfr_pkg::seen_wr_t             seen_wr,
  input  logic                          wrap,
  output logic                          busy
);
  import vfr_pkg::*;

  store_ent_t         store_mem [FRAME_BYTES];
  logic [EPOCH_W-1:0] seen_mem  [MAX_FRAGMENTS];

  logic              clr_r;
  logic [ADDR_W-1:0] clr_addr_r;
  store_wr_t         pend_st_r;
  seen_wr_t          pend_sn_r;

  logic               st_we;
  logic [ADDR_W-1:0]  st_addr;
  store_ent_t         st_wdata;
  logic               sn_we;
  logic [IDX_W-1:0]   sn_idx;
  logic [EPOCH_W-1:0] sn_wtag;

  // write port select: normal traffic, or the clearing sweep with the held-back writes
  always_comb begin
    st_we         = store_wr.we && !wrap;
    st_addr       = store_wr.addr;
    st_wdata.tag  = store_wr.tag;
    st_wdata.data = store_wr.data;
    sn_we         = seen_wr.we && !wrap;
    sn_idx        = seen_wr.idx;
    sn_wtag       = seen_wr.tag;
    if (clr_r) begin
      st_we         = 1'b1;
      st_addr       = clr_addr_r;
      st_wdata.data = pend_st_r.data;
      st_wdata.tag  = (pend_st_r.we && pend_st_r.addr == clr_addr_r) ? pend_st_r.tag
                                                                    : EPOCH_NONE;
      sn_we         = ({1'b0, clr_addr_r} < (ADDR_W + 1)'(MAX_FRAGMENTS));
      sn_idx        = clr_addr_r[IDX_W-1:0];
      sn_wtag       = (pend_sn_r.we && pend_sn_r.idx == sn_idx) ? pend_sn_r.tag : EPOCH_NONE;
    end
  end

  // clearing sweep after reset and on epoch wrap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r        <= 1'b1;
      clr_addr_r   <= '0;
      pend_st_r.we <= 1'b0;
      pend_sn_r.we <= 1'b0;
    end else if (wrap) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      pend_st_r  <= store_wr;
      pend_sn_r  <= seen_wr;
    end else if (clr_r) begin
      if (clr_addr_r == ADDR_W'(FRAME_BYTES - 1)) begin
        clr_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  // frame store with registered read
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_addr] <= st_wdata;
    end
    if (rd_en) begin
      store_rdata <= store_mem[store_raddr];
    end
  end

  // fragment seen tags with registered read
  always_ff @(posedge clk) begin
    if (sn_we) begin
      seen_mem[sn_idx] <= sn_wtag;
    end
    if (rd_en) begin
      seen_rtag <= seen_mem[seen_raddr];
    end
  end

  assign busy = clr_r;

endmodule

// ----- tb/tb_video_fragment_reassembler.sv -----
module tb_video_fragment_reassembler;
  timeunit 1ns;
  timeprecision 1ps;

  import vfr_pkg::*;

  // item kinds carried on in_tuser
  localparam bit MODE_FRAG = 1'b0;
  localparam bit MODE_READ = 1'b1;

  // result status codes carried on out_tuser
  typedef enum logic [2:0] {
    RES_ACCEPTED  = 3'd0,
    RES_DUPLICATE = 3'd1,
    RES_INVALID   = 3'd2,
    RES_COMPLETE  = 3'd3,
    RES_READ      = 3'd4
  } res_status_t;

  // fate of the fragment in flight, settled on its first byte
  typedef enum logic [1:0] {
    VD_NONE,
    VD_TAKE,
    VD_REPEAT,
    VD_REJECT
  } verdict_t;

  // ways of spoiling an otherwise good header
  typedef enum logic [1:0] {
    BRK_INDEX,
    BRK_LENGTH,
    BRK_ZERO_COUNT,
    BRK_HUGE_COUNT
  } broken_t;

  // in_tdata layout, last field in the lowest bits
  typedef struct packed {
    logic [15:0] read_address;
    logic [7:0]  data_byte;
    logic [31:0] fragment_length;
    logic [31:0] total_length;
    logic [31:0] fragment_offset;
    logic [15:0] frame_flags;
    logic [15:0] fragment_count;
    logic [15:0] fragment_index;
    logic [63:0] frame_timestamp;
    logic [31:0] frame_sequence;
  } vid_item_t;

  // out_tdata layout, last field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [7:0]  read_data;
    logic [31:0] bytes_gathered;
    logic [16:0] done_length;
    logic [15:0] done_flags;
    logic [63:0] done_timestamp;
    logic [31:0] done_sequence;
  } frame_desc_t;

  typedef struct packed {
    res_status_t status;
    frame_desc_t desc;
  } frame_report_t;

  typedef struct {
    bit          mode;
    vid_item_t   it;
    bit          last;
    bit          pin;
    res_status_t pst;
    logic [7:0]  pdata;
  } dir_row_t;

  localparam logic [63:0] TS_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // expected results in order of issue
  frame_report_t due_reports[$];
  int unsigned   mismatch_count = 0;
  int unsigned   useful_items = 0;
  int unsigned   tx_calm_left = 0;
  int unsigned   rx_calm_left = 0;
  int unsigned   rx_stall_left = 0;
  logic [63:0]   last_ts = '0;

  // reassembly state mirrored from the block
  logic [16:0]   lim_bytes;
  bit            frame_open;
  logic [31:0]   held_seq;
  logic [63:0]   held_ts;
  logic [15:0]   held_flg;
  logic [15:0]   held_cnt;
  logic [16:0]   held_len;
  logic [31:0]   gathered;
  int unsigned   byte_pos;
  verdict_t      verdict;
  int unsigned   lat_off;
  int unsigned   lat_len;
  logic [7:0]    asm_bytes[int unsigned];
  bit            idx_seen[int unsigned];

  dir_row_t      dir_tab[$];

  video_fragment_reassembler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle stretch length: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic vid_item_t rand_fields();
    vid_item_t v;
    v.read_address    = $urandom;
    v.data_byte       = $urandom;
    v.fragment_length = $urandom;
    v.total_length    = $urandom;
    v.fragment_offset = $urandom;
    v.frame_flags     = $urandom;
    v.fragment_count  = $urandom;
    v.fragment_index  = $urandom;
    v.frame_timestamp = {$urandom, $urandom};
    v.frame_sequence  = $urandom;
    return v;
  endfunction

  // descriptor of the held frame as it stands now
  function automatic frame_report_t held_report(res_status_t s, logic [7:0] d);
    frame_report_t r;
    r = '0;
    r.status              = s;
    r.desc.done_sequence  = held_seq;
    r.desc.done_timestamp = held_ts;
    r.desc.done_flags     = held_flg;
    r.desc.done_length    = held_len;
    r.desc.bytes_gathered = gathered;
    r.desc.read_data      = d;
    return r;
  endfunction

  // header check on the first byte of a fragment
  function automatic verdict_t header_verdict(vid_item_t it);
    longint unsigned tot, off, len, sum;
    tot = it.total_length;
    off = it.fragment_offset;
    len = it.fragment_length;
    if (it.fragment_count == 0 || it.fragment_index >= it.fragment_count ||
        it.fragment_count > MAX_FRAGMENTS || tot > lim_bytes || tot > FRAME_BYTES ||
        off > tot || len > tot - off) begin
      frame_open = 1'b0;
      return VD_REJECT;
    end
    // a change of sequence, timestamp, count or total length opens a fresh frame
    if (!frame_open || held_seq != it.frame_sequence || held_ts != it.frame_timestamp ||
        held_cnt != it.fragment_count || {15'd0, held_len} != it.total_length) begin
      frame_open = 1'b1;
      held_seq   = it.frame_sequence;
      held_ts    = it.frame_timestamp;
      held_flg   = it.frame_flags;
      held_cnt   = it.fragment_count;
      held_len   = tot[16:0];
      gathered   = '0;
      asm_bytes.delete();
      idx_seen.delete();
    end
    if (idx_seen.exists(it.fragment_index)) return VD_REPEAT;
    idx_seen[it.fragment_index] = 1'b1;
    sum      = gathered + len;
    gathered = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    lat_off  = off;
    lat_len  = len;
    return VD_TAKE;
  endfunction

  // advance the mirrored state by one accepted transaction
  task automatic reassemble_item(input bit mode, input vid_item_t it, input bit last);
    int unsigned a;
    res_status_t s;
    if (mode == MODE_READ) begin
      a = it.read_address;
      useful_items++;
      if (a < held_len && asm_bytes.exists(a))
        due_reports.push_back(held_report(RES_READ, asm_bytes[a]));
      else
        due_reports.push_back(held_report(RES_READ, 8'h00));
      return;
    end
    if (byte_pos == 0) verdict = header_verdict(it);
    if (verdict == VD_TAKE || last) useful_items++;
    if (verdict == VD_TAKE && byte_pos < lat_len) begin
      a = lat_off + byte_pos;
      if (a < FRAME_BYTES) asm_bytes[a] = it.data_byte;
    end
    if (byte_pos < FRAME_BYTES) byte_pos++;
    if (!last) return;
    // fragment end: report and maybe close the frame
    if (verdict == VD_REJECT) begin
      s = RES_INVALID;
    end else begin
      s = (verdict == VD_REPEAT) ? RES_DUPLICATE : RES_ACCEPTED;
      if (frame_open && gathered >= {15'd0, held_len}) begin
        s = RES_COMPLETE;
        frame_open = 1'b0;
      end
    end
    byte_pos = 0;
    verdict  = VD_NONE;
    due_reports.push_back(held_report(s, 8'h00));
  endtask

  // offer one transaction, with an optional idle stretch before it
  task automatic push_item(input bit mode, input vid_item_t it, input bit last);
    int unsigned gap;
    if (tx_calm_left > 0) tx_calm_left--;
    else if ($urandom_range(0, 199) == 0) tx_calm_left = $urandom_range(40, 150);
    if (tx_calm_left == 0 && $urandom_range(0, 99) < 30) begin
      gap = idle_len();
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= it;
    in_tlast  <= last;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    reassemble_item(mode, it, last);
  endtask

  task automatic read_at(input logic [15:0] addr);
    vid_item_t q;
    q = rand_fields();
    q.read_address = addr;
    push_item(MODE_READ, q, $urandom_range(0, 1));
  endtask

  // payload bytes of one fragment, sometimes with a wrong byte count
  task automatic send_fragment(input vid_item_t h, input bit allow_skew);
    int unsigned n;
    if (h.fragment_length == 0) n = 1;
    else if (h.fragment_length > 300) n = $urandom_range(1, 3);
    else n = h.fragment_length;
    if (allow_skew && $urandom_range(0, 99) < 6) n = $urandom_range(n > 2 ? n - 2 : 1, n + 2);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 7) read_at(16'($urandom_range(0, held_len + 1)));
      h.data_byte    = $urandom;
      h.read_address = $urandom;
      push_item(MODE_FRAG, h, k == n - 1);
    end
  endtask

  // sender waits for every outstanding result, then a few quiet cycles
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [16:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    lim_bytes    = v;
  endtask

  // one random frame: split, shuffled, with duplicates, damage and reads
  task automatic run_frame();
    vid_item_t   h, b;
    int unsigned tot, cnt, r, j, tmp, room;
    int unsigned cuts[$];
    int unsigned offs[16], lens[16], order[16];
    h = rand_fields();
    h.frame_sequence  = $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : $urandom;
    h.frame_timestamp = ($urandom_range(0, 2) == 0) ? last_ts : {$urandom, $urandom};
    last_ts = h.frame_timestamp;
    // sparse frame: large geometry, a few short fragments
    if ($urandom_range(0, 99) < 6) begin
      tot = $urandom_range(0, 1) ? 65536 : $urandom_range(1, 65536);
      cnt = $urandom_range(1, MAX_FRAGMENTS);
      h.total_length   = tot;
      h.fragment_count = cnt;
      repeat ($urandom_range(1, 3)) begin
        h.fragment_index  = $urandom_range(0, cnt - 1);
        h.fragment_offset = $urandom_range(0, tot);
        room = tot - h.fragment_offset;
        h.fragment_length = $urandom_range(0, room < 8 ? room : 8);
        h.frame_flags     = $urandom;
        send_fragment(h, 1'b0);
        read_at(h.fragment_offset[15:0]);
      end
      return;
    end
    r   = $urandom_range(0, 99);
    tot = (r < 5) ? 0 : (r < 85) ? $urandom_range(1, 40) : $urandom_range(41, 256);
    cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    for (int unsigned k = 1; k < cnt; k++) cuts.push_back($urandom_range(0, tot));
    cuts.sort();
    cuts.push_front(0);
    cuts.push_back(tot);
    for (int unsigned k = 0; k < cnt; k++) begin
      offs[k]  = cuts[k];
      lens[k]  = cuts[k + 1] - cuts[k];
      order[k] = k;
    end
    for (int unsigned k = cnt - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    h.total_length   = tot;
    h.fragment_count = cnt;
    for (int unsigned k = 0; k < cnt; k++) begin
      if ($urandom_range(0, 99) < 8) continue;
      h.fragment_index  = order[k];
      h.fragment_offset = offs[order[k]];
      h.fragment_length = lens[order[k]];
      h.frame_flags     = $urandom;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        b = h;
        case (broken_t'($urandom_range(0, 3)))
          BRK_INDEX:      b.fragment_index  = cnt;
          BRK_LENGTH:     b.fragment_length = tot - offs[order[k]] + 1;
          BRK_ZERO_COUNT: b.fragment_count  = 0;
          BRK_HUGE_COUNT: b.fragment_count  = $urandom_range(MAX_FRAGMENTS + 1, 65535);
        endcase
        send_fragment(b, 1'b1);
      end else if (r < 7) begin
        send_fragment(rand_fields(), 1'b1);
      end
      send_fragment(h, 1'b1);
      if ($urandom_range(0, 99) < 8) send_fragment(h, 1'b1);
    end
    if ($urandom_range(0, 1)) repeat ($urandom_range(1, 4)) read_at(16'($urandom_range(0, tot + 1)));
    if ($urandom_range(0, 99) < 3) settle();
  endtask

  // directed table helpers
  function automatic dir_row_t frag(logic [31:0] seq, logic [63:0] ts, logic [15:0] idx,
                                    logic [15:0] cnt, logic [15:0] flg, logic [31:0] off,
                                    logic [31:0] tot, logic [31:0] len, logic [7:0] dat,
                                    bit last);
    dir_row_t r;
    r.mode = MODE_FRAG;
    r.it   = rand_fields();
    r.it.frame_sequence  = seq;
    r.it.frame_timestamp = ts;
    r.it.fragment_index  = idx;
    r.it.fragment_count  = cnt;
    r.it.frame_flags     = flg;
    r.it.fragment_offset = off;
    r.it.total_length    = tot;
    r.it.fragment_length = len;
    r.it.data_byte       = dat;
    r.last  = last;
    r.pin   = 1'b0;
    r.pst   = RES_ACCEPTED;
    r.pdata = '0;
    return r;
  endfunction

  function automatic dir_row_t rd(logic [15:0] addr);
    dir_row_t r;
    r.mode  = MODE_READ;
    r.it    = rand_fields();
    r.it.read_address = addr;
    r.last  = 1'b0;
    r.pin   = 1'b0;
    r.pst   = RES_READ;
    r.pdata = '0;
    return r;
  endfunction

  function automatic dir_row_t pin(dir_row_t r, res_status_t s, logic [7:0] d);
    r.pin   = 1'b1;
    r.pst   = s;
    r.pdata = d;
    return r;
  endfunction

  task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch %s: expected %h got %h", what, want, got_v);
  endtask

  // result side: random stalls and in-order comparison
  always @(posedge clk) begin
    frame_report_t e;
    frame_desc_t   got;
    if (out_tvalid && out_tready) begin
      got = out_tdata;
      if (due_reports.size() == 0) begin
        flag("unexpected result, status", '0, out_tuser);
      end else begin
        e = due_reports.pop_front();
        if (out_tuser !== e.status) flag("status", e.status, out_tuser);
        if (got.done_sequence !== e.desc.done_sequence)
          flag("done_sequence", e.desc.done_sequence, got.done_sequence);
        if (got.done_timestamp !== e.desc.done_timestamp)
          flag("done_timestamp", e.desc.done_timestamp, got.done_timestamp);
        if (got.done_flags !== e.desc.done_flags)
          flag("done_flags", e.desc.done_flags, got.done_flags);
        if (got.done_length !== e.desc.done_length)
          flag("done_length", e.desc.done_length, got.done_length);
        if (got.bytes_gathered !== e.desc.bytes_gathered)
          flag("bytes_gathered", e.desc.bytes_gathered, got.bytes_gathered);
        if (got.read_data !== e.desc.read_data)
          flag("read_data", e.desc.read_data, got.read_data);
      end
    end
    if (rx_calm_left > 0) rx_calm_left--;
    else if ($urandom_range(0, 99) == 0) rx_calm_left = $urandom_range(100, 300);
    if (rx_stall_left > 0) begin
      out_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (rx_calm_left == 0 && $urandom_range(0, 99) < 30) rx_stall_left = idle_len();
    end
  end

  // run limit, well above the slowest correct run including the clearing pass
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus
  initial begin
    logic [16:0] cfg_plan[$];
    int unsigned mark;
    lim_bytes  = 17'd65536;
    frame_open = 1'b0;
    held_seq   = '0;
    held_ts    = '0;
    held_flg   = '0;
    held_cnt   = '0;
    held_len   = '0;
    gathered   = '0;
    byte_pos   = 0;
    verdict    = VD_NONE;
    lat_off    = 0;
    lat_len    = 0;

    dir_tab = '{
      // nothing held after reset
      pin(rd(16'd0), RES_READ, 8'h00),
      // header rejections
      pin(frag(1, 64'd1, 0, 0, 0, 0, 4, 1, 8'h01, 1'b1), RES_INVALID, 8'h00),
      pin(frag(1, 64'd1, 2, 2, 0, 0, 4, 1, 8'h01, 1'b1), RES_INVALID, 8'h00),
      pin(frag(1, 64'd1, 0, 1025, 0, 0, 4, 1, 8'h01, 1'b1), RES_INVALID, 8'h00),
      pin(frag(1, 64'd1, 0, 1, 0, 0, 65537, 1, 8'h01, 1'b1), RES_INVALID, 8'h00),
      pin(frag(1, 64'd1, 0, 1, 0, 5, 4, 0, 8'h01, 1'b1), RES_INVALID, 8'h00),
      pin(frag(1, 64'd1, 0, 1, 0, 2, 4, 3, 8'h01, 1'b1), RES_INVALID, 8'h00),
      // two-fragment frame with a read inside a fragment
      frag(10, TS_ONES, 0, 2, 16'hFFFF, 0, 4, 2, 8'hAA, 1'b0),
      pin(rd(16'd0), RES_READ, 8'hAA),
      pin(frag(10, TS_ONES, 0, 2, 16'hFFFF, 0, 4, 2, 8'h55, 1'b1), RES_ACCEPTED, 8'h00),
      // repeated index that also ends early
      pin(frag(10, TS_ONES, 0, 2, 16'h0000, 0, 4, 2, 8'h99, 1'b1), RES_DUPLICATE, 8'h00),
      frag(10, TS_ONES, 1, 2, 16'h0000, 2, 4, 2, 8'h00, 1'b0),
      frag(10, TS_ONES, 1, 2, 16'h0000, 2, 4, 2, 8'hFF, 1'b0),
      // byte beyond the fragment length is dropped
      pin(frag(10, TS_ONES, 1, 2, 16'h0000, 2, 4, 2, 8'h77, 1'b1), RES_COMPLETE, 8'h00),
      pin(rd(16'd3), RES_READ, 8'hFF),
      pin(rd(16'd4), RES_READ, 8'h00),
      // empty frame completes at once
      pin(frag(32'hFFFF_FFFF, 64'd0, 0, 1, 16'h1234, 0, 0, 0, 8'h33, 1'b1),
          RES_COMPLETE, 8'h00),
      // last index, last byte of the largest frame
      pin(frag(20, 64'd0, 1023, 1024, 16'h0000, 65535, 65536, 1, 8'h5A, 1'b1),
          RES_ACCEPTED, 8'h00),
      pin(rd(16'hFFFF), RES_READ, 8'h5A),
      pin(rd(16'd0), RES_READ, 8'h00),
      // rejection drops the frame but keeps it readable
      pin(frag(20, 64'd0, 0, 0, 16'h0000, 0, 65536, 1, 8'h01, 1'b1), RES_INVALID, 8'h00),
      pin(rd(16'hFFFF), RES_READ, 8'h5A),
      // same header restarts the frame and clears the written marks
      pin(frag(20, 64'd0, 0, 1024, 16'h00FF, 0, 65536, 1, 8'h11, 1'b1),
          RES_ACCEPTED, 8'h00),
      pin(rd(16'hFFFF), RES_READ, 8'h00)
    };

    cfg_plan = '{17'd32, 17'd0, 17'h1FFFF, 17'($urandom_range(0, 131071)), 17'd65535,
                 17'd65536};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      push_item(dir_tab[i].mode, dir_tab[i].it, dir_tab[i].last);
      if (dir_tab[i].pin) begin
        due_reports[$].status         = dir_tab[i].pst;
        due_reports[$].desc.read_data = dir_tab[i].pdata;
      end
    end
    settle();

    // random phases, one frame length limit each
    foreach (cfg_plan[p]) begin
      cfg_write(cfg_plan[p]);
      mark = useful_items;
      while (useful_items - mark < 180) run_frame();
      settle();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
